>>> sv/orgb_pkg.sv
// shared constants, types and tables for the rgb to orgb converter
package orgb_pkg;

  // fixed-point setup
  localparam int FRAC_BITS     = 12;
  localparam int CORDIC_STAGES = 14;
  localparam int GUARD         = 4;
  localparam int CH_W          = 12;

  // matrix coefficients, round half up
  localparam int K_R   = (2990 * (1 << FRAC_BITS) + 5000) / 10000;
  localparam int K_G   = (5870 * (1 << FRAC_BITS) + 5000) / 10000;
  localparam int K_B   = (1140 * (1 << FRAC_BITS) + 5000) / 10000;
  localparam int K_866 = (8660 * (1 << FRAC_BITS) + 5000) / 10000;

  // widths
  localparam int PW   = CH_W + FRAC_BITS + 1;      // luma product
  localparam int SW   = PW + 2;                    // luma sum
  localparam int DW   = CH_W + 2;                  // channel difference, signed
  localparam int P2W  = DW + FRAC_BITS + 1;        // c2 product, signed
  localparam int C2W  = P2W + GUARD;               // c2 product with guard bits
  localparam int CW   = CH_W + GUARD + 2;          // chroma, signed
  localparam int XW   = CW + 4;                    // cordic vector, signed
  localparam int ZW   = 37;                        // binary angle, signed
  localparam int GW   = 31;                        // gain constant, signed
  localparam int MW   = XW + GW;                   // gain product
  localparam int OW   = 14;                        // chroma output

  localparam logic signed [ZW-1:0] HALF_TURN   = ZW'(64'sd1 <<< 31);
  localparam logic signed [ZW-1:0] EIGHTH_TURN = ZW'(64'sd1 <<< 29);
  localparam logic signed [ZW-1:0] FULL_TURN   = ZW'(64'sd1 <<< 32);
  localparam logic signed [GW-1:0] GAIN_INV    = GW'(652032874);
  localparam int                   MSHIFT      = 30 + GUARD;
  localparam logic signed [OW-1:0] SAT_HI      = OW'(4096);
  localparam logic signed [OW-1:0] SAT_LO      = -OW'(4096);

  // one word between front and back
  typedef struct packed {
    logic [CH_W-1:0]      luma;
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] c2;
  } orgb_item_t;

  // arctangent table, full turn is 2^32
  function automatic logic signed [ZW-1:0] atan_at(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = ZW'(536870912);
      5'd1:  v = ZW'(316933406);
      5'd2:  v = ZW'(167458907);
      5'd3:  v = ZW'(85004756);
      5'd4:  v = ZW'(42667331);
      5'd5:  v = ZW'(21354465);
      5'd6:  v = ZW'(10679838);
      5'd7:  v = ZW'(5340245);
      5'd8:  v = ZW'(2670163);
      5'd9:  v = ZW'(1335087);
      5'd10: v = ZW'(667544);
      5'd11: v = ZW'(333772);
      5'd12: v = ZW'(166886);
      5'd13: v = ZW'(83443);
      5'd14: v = ZW'(41722);
      5'd15: v = ZW'(20861);
      5'd16: v = ZW'(10430);
      5'd17: v = ZW'(5215);
      5'd18: v = ZW'(2608);
      5'd19: v = ZW'(1304);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/orgb_front.sv
// front end: matrix products, luma and opponent chroma
module orgb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [orgb_pkg::CH_W-1:0]    red,
  input  logic [orgb_pkg::CH_W-1:0]    green,
  input  logic [orgb_pkg::CH_W-1:0]    blue,
  input  logic                         q_full,
  output logic                         push,
  output orgb_pkg::orgb_item_t         item
);

  logic                                 en;
  logic                                 s1_v_r, s2_v_r;
  logic [orgb_pkg::PW-1:0]              pr_r, pg_r, pb_r;
  logic signed [orgb_pkg::P2W-1:0]      p866_r;
  logic signed [orgb_pkg::DW-1:0]       craw_r;
  logic [orgb_pkg::SW-1:0]              sum;
  logic signed [orgb_pkg::DW-1:0]       dif;
  logic signed [orgb_pkg::C2W-1:0]      c2w;
  orgb_pkg::orgb_item_t                 item_r;

  // whole front stalls together
  assign en       = !s2_v_r || !q_full;
  assign in_ready = en;
  assign push     = s2_v_r && en;
  assign item     = item_r;

  assign dif = orgb_pkg::DW'($signed({1'b0, red})) - orgb_pkg::DW'($signed({1'b0, green}));

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      pr_r   <= orgb_pkg::PW'(red)   * orgb_pkg::PW'(orgb_pkg::K_R);
      pg_r   <= orgb_pkg::PW'(green) * orgb_pkg::PW'(orgb_pkg::K_G);
      pb_r   <= orgb_pkg::PW'(blue)  * orgb_pkg::PW'(orgb_pkg::K_B);
      p866_r <= orgb_pkg::P2W'(dif) * orgb_pkg::P2W'(orgb_pkg::K_866);
      craw_r <= orgb_pkg::DW'(red) + orgb_pkg::DW'(green)
                - orgb_pkg::DW'({blue, 1'b0});
    end
  end

  // stage 2: rounding and saturation
  assign sum = orgb_pkg::SW'(pr_r) + orgb_pkg::SW'(pg_r) + orgb_pkg::SW'(pb_r)
               + orgb_pkg::SW'(1 << (orgb_pkg::FRAC_BITS - 1));
  assign c2w = (orgb_pkg::C2W'(p866_r) <<< orgb_pkg::GUARD)
               + orgb_pkg::C2W'(1 << (orgb_pkg::FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      if ((sum >> orgb_pkg::FRAC_BITS) > orgb_pkg::SW'(4095))
        item_r.luma <= '1;
      else
        item_r.luma <= orgb_pkg::CH_W'(sum >> orgb_pkg::FRAC_BITS);
      item_r.c1 <= orgb_pkg::CW'(craw_r) <<< (orgb_pkg::GUARD - 1);
      item_r.c2 <= orgb_pkg::CW'(c2w >>> orgb_pkg::FRAC_BITS);
    end
  end

endmodule

>>> sv/orgb_queue.sv
// two-word queue between front and back
module orgb_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  orgb_pkg::orgb_item_t  push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output orgb_pkg::orgb_item_t  head
);

  orgb_pkg::orgb_item_t mem_r [0:1];
  logic                 wp_r, rp_r;
  logic [1:0]           cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop && not_empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop && not_empty);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

endmodule

>>> sv/orgb_back.sv
// back end: cordic vectoring, angle remap, cordic rotation, gain and saturation
module orgb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_not_empty,
  input  orgb_pkg::orgb_item_t         q_head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [orgb_pkg::CH_W-1:0]    luma,
  output logic signed [orgb_pkg::OW-1:0] yellow_blue,
  output logic signed [orgb_pkg::OW-1:0] red_green
);

  localparam int N = orgb_pkg::CORDIC_STAGES;
  localparam int XW = orgb_pkg::XW;
  localparam int ZW = orgb_pkg::ZW;

  logic en;

  // vectoring chain
  logic                         vv_r [0:N];
  logic signed [XW-1:0]         vx_r [0:N];
  logic signed [XW-1:0]         vy_r [0:N];
  logic signed [ZW-1:0]         vz_r [0:N];
  orgb_pkg::orgb_item_t         vi_r [0:N];

  // remap stages
  logic                         ma_v_r;
  logic signed [ZW-1:0]         ma_t0_r, ma_z_r;
  orgb_pkg::orgb_item_t         ma_i_r;
  logic signed [ZW-1:0]         tm, tm3, t0;

  // rotation chain
  logic                         rv_r [0:N];
  logic signed [XW-1:0]         rx_r [0:N];
  logic signed [XW-1:0]         ry_r [0:N];
  logic signed [ZW-1:0]         ra_r [0:N];
  logic [orgb_pkg::CH_W-1:0]    rl_r [0:N];
  logic                         rzero_r [0:N];

  // gain and output
  logic                         gv_r;
  logic signed [orgb_pkg::MW-1:0] gx_r, gy_r;
  logic [orgb_pkg::CH_W-1:0]    gl_r;
  logic                         gz_r;
  logic signed [orgb_pkg::MW-1:0] gxr, gyr;
  logic                         out_v_r;
  logic [orgb_pkg::CH_W-1:0]    out_l_r;
  logic signed [orgb_pkg::OW-1:0] out_yb_r, out_rg_r;

  // whole back advances when the output word can move
  assign en          = !out_v_r || out_ready;
  assign pop         = en;
  assign out_valid   = out_v_r;
  assign luma        = out_l_r;
  assign yellow_blue = out_yb_r;
  assign red_green   = out_rg_r;

  // entry: fold left half plane
  always_ff @(posedge clk) begin
    if (!rst_n) vv_r[0] <= 1'b0;
    else if (en) vv_r[0] <= q_not_empty;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vi_r[0] <= q_head;
      if (q_head.c1 < 0) begin
        vx_r[0] <= -XW'(q_head.c1);
        vy_r[0] <= -XW'(q_head.c2);
        vz_r[0] <= (q_head.c2 < 0) ? -orgb_pkg::HALF_TURN : orgb_pkg::HALF_TURN;
      end else begin
        vx_r[0] <= XW'(q_head.c1);
        vy_r[0] <= XW'(q_head.c2);
        vz_r[0] <= '0;
      end
    end
  end

  // vectoring stages
  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [XW-1:0] dx, dy;
    assign dx = vy_r[i] >>> i;
    assign dy = vx_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) vv_r[i+1] <= 1'b0;
      else if (en) vv_r[i+1] <= vv_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vi_r[i+1] <= vi_r[i];
        if (vy_r[i] >= 0) begin
          vx_r[i+1] <= vx_r[i] + dx;
          vy_r[i+1] <= vy_r[i] - dy;
          vz_r[i+1] <= vz_r[i] + orgb_pkg::atan_at(5'(i));
        end else begin
          vx_r[i+1] <= vx_r[i] - dx;
          vy_r[i+1] <= vy_r[i] + dy;
          vz_r[i+1] <= vz_r[i] - orgb_pkg::atan_at(5'(i));
        end
      end
    end
  end

  // remap, first half: magnitude of the target angle
  assign tm  = (vz_r[N] < 0) ? -vz_r[N] : vz_r[N];
  assign tm3 = tm + (tm <<< 1);
  assign t0  = ((tm3 <<< 1) < orgb_pkg::FULL_TURN) ? (tm3 >>> 1)
             : orgb_pkg::EIGHTH_TURN + (tm3 >>> 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ma_v_r <= 1'b0;
    end else if (en) begin
      ma_v_r <= vv_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_t0_r <= t0;
      ma_z_r  <= vz_r[N];
      ma_i_r  <= vi_r[N];
    end
  end

  // remap, second half: rotation angle
  always_ff @(posedge clk) begin
    if (en) begin
      ra_r[0]    <= ((ma_z_r < 0) ? -ma_t0_r : ma_t0_r) - ma_z_r;
      rx_r[0]    <= XW'(ma_i_r.c1);
      ry_r[0]    <= XW'(ma_i_r.c2);
      rl_r[0]    <= ma_i_r.luma;
      rzero_r[0] <= (ma_i_r.c1 == 0) && (ma_i_r.c2 == 0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rv_r[0] <= 1'b0;
    else if (en) rv_r[0] <= ma_v_r;
  end

  // rotation stages
  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [XW-1:0] dx, dy;
    assign dx = ry_r[i] >>> i;
    assign dy = rx_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) rv_r[i+1] <= 1'b0;
      else if (en) rv_r[i+1] <= rv_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rl_r[i+1]    <= rl_r[i];
        rzero_r[i+1] <= rzero_r[i];
        if (ra_r[i] >= 0) begin
          rx_r[i+1] <= rx_r[i] - dx;
          ry_r[i+1] <= ry_r[i] + dy;
          ra_r[i+1] <= ra_r[i] - orgb_pkg::atan_at(5'(i));
        end else begin
          rx_r[i+1] <= rx_r[i] + dx;
          ry_r[i+1] <= ry_r[i] - dy;
          ra_r[i+1] <= ra_r[i] + orgb_pkg::atan_at(5'(i));
        end
      end
    end
  end

  // gain removal
  always_ff @(posedge clk) begin
    if (!rst_n) gv_r <= 1'b0;
    else if (en) gv_r <= rv_r[N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r <= orgb_pkg::MW'(rx_r[N]) * orgb_pkg::MW'(orgb_pkg::GAIN_INV);
      gy_r <= orgb_pkg::MW'(ry_r[N]) * orgb_pkg::MW'(orgb_pkg::GAIN_INV);
      gl_r <= rl_r[N];
      gz_r <= rzero_r[N];
    end
  end

  // round half up and saturate
  assign gxr = (gx_r + (orgb_pkg::MW'(1) <<< (orgb_pkg::MSHIFT - 1))) >>> orgb_pkg::MSHIFT;
  assign gyr = (gy_r + (orgb_pkg::MW'(1) <<< (orgb_pkg::MSHIFT - 1))) >>> orgb_pkg::MSHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= gv_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_l_r <= gl_r;
      if (gz_r)                                     out_yb_r <= '0;
      else if (gxr > orgb_pkg::MW'(orgb_pkg::SAT_HI)) out_yb_r <= orgb_pkg::SAT_HI;
      else if (gxr < orgb_pkg::MW'(orgb_pkg::SAT_LO)) out_yb_r <= orgb_pkg::SAT_LO;
      else                                          out_yb_r <= orgb_pkg::OW'(gxr);
      if (gz_r)                                     out_rg_r <= '0;
      else if (gyr > orgb_pkg::MW'(orgb_pkg::SAT_HI)) out_rg_r <= orgb_pkg::SAT_HI;
      else if (gyr < orgb_pkg::MW'(orgb_pkg::SAT_LO)) out_rg_r <= orgb_pkg::SAT_LO;
      else                                          out_rg_r <= orgb_pkg::OW'(gyr);
    end
  end

endmodule

>>> sv/rgb_to_orgb_convert.sv
// top level of the rgb to orgb converter
//
//  channel | direction | tdata fields, low bit first        | tuser/tlast
//  in_     | slave     | red[11:0] green[23:12] blue[35:24] | none
//  out_    | master    | luma[11:0] yellow_blue[25:12]      | none
//          |           | red_green[39:26]                   |
//
// one pixel per clock sustained while the queue and the output accept words;
// the two unrolled cordic pipelines in the back set most of the depth
// reset clears valid bits, queue pointers and fill count only, no clearing pass
// front and back stall separately; the two-word queue absorbs the difference
module rgb_to_orgb_convert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // red, green, blue, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // luma, yellow_blue, red_green
);

  logic                 q_full, q_push, q_pop, q_ne;
  orgb_pkg::orgb_item_t f_item, q_head;
  logic [orgb_pkg::CH_W-1:0]      o_luma;
  logic signed [orgb_pkg::OW-1:0] o_yb, o_rg;

  orgb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .red      (in_tdata[11:0]),
    .green    (in_tdata[23:12]),
    .blue     (in_tdata[35:24]),
    .q_full   (q_full),
    .push     (q_push),
    .item     (f_item)
  );

  orgb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_ne),
    .head      (q_head)
  );

  orgb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_ne),
    .q_head      (q_head),
    .pop         (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .luma        (o_luma),
    .yellow_blue (o_yb),
    .red_green   (o_rg)
  );

  assign out_tdata = {o_rg, o_yb, o_luma};

endmodule

>>> sv/orgb_checker.sv
// port-level checks for the rgb to orgb converter
module orgb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // yellow-blue stays inside saturation limits
  a_yb: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[25:12]) <= 14'sd4096)
                && ($signed(out_tdata[25:12]) >= -14'sd4096))
    else $error("yellow_blue out of range");

  // red-green stays inside saturation limits
  a_rg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[39:26]) <= 14'sd4096)
                && ($signed(out_tdata[39:26]) >= -14'sd4096))
    else $error("red_green out of range");

endmodule

bind rgb_to_orgb_convert orgb_checker u_orgb_checker (.*);
